// File: hdl/mf5_pkg.sv
package mf5_pkg;

  localparam int unsigned WinSize = 5;
  localparam int unsigned WinArea = 25;
  localparam int unsigned MedianRank = 12;
  localparam int unsigned MaxCols = 256;

  // Configuration register indexes
  typedef enum logic [0:0] {
    RegWidth  = 1'b0,
    RegHeight = 1'b1
  } reg_idx_e;

  typedef logic [WinArea-1:0][7:0] win_t;

  // Sideband that travels with a window through the sort chain
  typedef struct packed {
    logic        valid;
    logic [7:0]  col;
    logic [11:0] row;
    logic        done;
  } meta_t;

endpackage

// File: hdl/median_filter_5x5.sv
// Streaming 5x5 median filter for 8-bit grey pixels in raster order.
// Input channel: in_valid_i / in_ready_o with pixel_i, one pixel per item.
// Output channel: out_valid_o / out_ready_i with median_value_o,
// center_col_o, center_row_o and frame_done_o. Only interior centers
// (two or more pixels from every edge) give an item; the pixel arriving at
// (col,row) produces the result for (col-2,row-2).
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i (0 = width,
// 1 = height) and cfg_data_i; writes are always taken. Write it while idle.
// Throughput: one pixel per cycle while the output is not blocked. A taken
// pixel is registered with its line-store read; the window shift feeds the
// first of 25 odd-even transposition sort cells, then the output register.
// When the receiver stalls with a result waiting, the pipeline keeps moving
// as long as no finished result reaches its end; then in_ready_o drops until
// the output is taken.
// Reset clears the raster counters and pipeline valid bits and sets width
// and height to 256; line stores need no clearing.
module median_filter_5x5 #(
  parameter int unsigned LINE_WIDTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pixel_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  median_value_o,
  output logic [7:0]  center_col_o,
  output logic [11:0] center_row_o,
  output logic        frame_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  logic [8:0]     width_q;
  logic [11:0]    height_q;
  logic           en, acc;
  logic           out_valid_q;
  mf5_pkg::win_t  win [mf5_pkg::WinArea+1];
  mf5_pkg::meta_t meta [mf5_pkg::WinArea+1];
  mf5_pkg::meta_t last;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 12'd256;
    end else if (cfg_valid_i) begin
      unique case (mf5_pkg::reg_idx_e'(cfg_index_i))
        mf5_pkg::RegWidth:  width_q  <= cfg_data_i[8:0];
        mf5_pkg::RegHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall only when a finished result would hit a full output register
  assign last       = meta[mf5_pkg::WinArea];
  assign en         = !(out_valid_q && !out_ready_i && last.valid);
  assign in_ready_o = en;
  assign acc        = in_valid_i && en;

  mf5_front #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .acc_i   (acc),
    .pixel_i (pixel_i),
    .width_i (width_q),
    .height_i(height_q),
    .win_o   (win[0]),
    .meta_o  (meta[0])
  );

  // Sort chain of alternating phases
  for (genvar g = 0; g < mf5_pkg::WinArea; g++) begin : g_cell
    mf5_cell #(
      .ODD(1'(g % 2))
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .win_i (win[g]),
      .meta_i(meta[g]),
      .win_o (win[g+1]),
      .meta_o(meta[g+1])
    );
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && last.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && last.valid) begin
      median_value_o <= win[mf5_pkg::WinArea][mf5_pkg::MedianRank];
      center_col_o   <= last.col;
      center_row_o   <= last.row;
      frame_done_o   <= last.done;
    end
  end

  assign out_valid_o = out_valid_q;

  // A waiting result blocks the input only when another is ready behind it
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && last.valid |-> !in_ready_o)
    else $error("input taken while the output is blocked");

  // A blocked result is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(median_value_o)
      && $stable(center_row_o))
    else $error("waiting result lost");

  // Results carry interior coordinates
  a_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> center_col_o >= 8'd2 && center_row_o >= 12'd2)
    else $error("border center on output");

endmodule

// File: hdl/mf5_cell.sv
module mf5_cell #(
  parameter bit ODD = 1'b0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  mf5_pkg::win_t win_i,
  input  mf5_pkg::meta_t meta_i,
  output mf5_pkg::win_t win_o,
  output mf5_pkg::meta_t meta_o
);

  localparam int unsigned First = ODD ? 1 : 0;

  mf5_pkg::win_t  win_d, win_q;
  mf5_pkg::meta_t meta_q;

  // Compare and swap neighbor pairs of this phase
  always_comb begin
    win_d = win_i;
    for (int i = First; i + 1 < mf5_pkg::WinArea; i += 2) begin
      if (win_i[i] > win_i[i+1]) begin
        win_d[i]   = win_i[i+1];
        win_d[i+1] = win_i[i];
      end
    end
  end

  // Hold the window after this phase's swaps
  always_ff @(posedge clk_i) begin
    if (en_i) win_q <= win_d;
  end

  // Advance the sideband
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_q <= '0;
    end else if (en_i) begin
      meta_q <= meta_i;
    end
  end

  assign win_o  = win_q;
  assign meta_o = meta_q;

endmodule

// File: hdl/mf5_front.sv
module mf5_front #(
  parameter int unsigned LINE_WIDTH = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           acc_i,
  input  logic [7:0]     pixel_i,
  input  logic [8:0]     width_i,
  input  logic [11:0]    height_i,
  output mf5_pkg::win_t  win_o,
  output mf5_pkg::meta_t meta_o
);

  localparam int unsigned SW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;
  localparam int unsigned Cap = (LINE_WIDTH < mf5_pkg::MaxCols) ? LINE_WIDTH
                                                                : mf5_pkg::MaxCols;
  localparam int unsigned LastSlot = LINE_WIDTH - 1;

  logic [7:0]    col_d, col_q;
  logic [11:0]   row_d, row_q;
  logic [8:0]    w_use;
  logic [11:0]   h_use;
  logic          row_end, frame_end;
  logic [SW-1:0] slot;

  logic [31:0]   mem_q [LINE_WIDTH];
  logic [31:0]   rd_q;

  logic          s1_valid_q, s1_res_q, s1_done_q;
  logic [7:0]    s1_px_q, s1_col_q;
  logic [11:0]   s1_row_q;
  logic [SW-1:0] s1_slot_q;

  logic          fwd_valid_q;
  logic [SW-1:0] fwd_slot_q;
  logic [31:0]   fwd_data_q;

  logic [31:0]   col_word, wdata;
  logic          proc;
  mf5_pkg::win_t win_d, win_q;

  // Clamp the frame size to at least 5 and the width to what the line stores can hold
  always_comb begin
    if (width_i < 9'd5) begin
      w_use = 9'd5;
    end else if (32'(width_i) > Cap) begin
      w_use = 9'(Cap);
    end else begin
      w_use = width_i;
    end
    h_use = (height_i < 12'd5) ? 12'd5 : height_i;
  end

  assign row_end   = ({1'b0, col_q} + 9'd1) >= w_use;
  assign frame_end = row_end && (({1'b0, row_q} + 13'd1) >= {1'b0, h_use});

  always_comb begin
    if (32'(col_q) > LastSlot) begin
      slot = SW'(LastSlot);
    end else begin
      slot = SW'(col_q);
    end
  end

  // Step the raster counters on each item
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (frame_end) begin
      col_d = '0;
      row_d = '0;
    end else if (row_end) begin
      col_d = '0;
      row_d = row_q + 12'd1;
    end else begin
      col_d = col_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Capture the item and its line-store column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en_i) begin
      s1_valid_q <= acc_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_px_q   <= pixel_i;
      s1_slot_q <= slot;
      s1_res_q  <= (col_q >= 8'd4) && (row_q >= 12'd4);
      s1_col_q  <= col_q - 8'd2;
      s1_row_q  <= row_q - 12'd2;
      s1_done_q <= frame_end;
    end
  end

  // Line store: one word per column, four rows packed
  assign proc = en_i && s1_valid_q;

  always_ff @(posedge clk_i) begin
    if (acc_i) rd_q <= mem_q[slot];
    if (proc)  mem_q[s1_slot_q] <= wdata;
  end

  // Forward the last write when the same column is read right after it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (proc) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      fwd_slot_q <= s1_slot_q;
      fwd_data_q <= wdata;
    end
  end

  assign col_word = (fwd_valid_q && (fwd_slot_q == s1_slot_q)) ? fwd_data_q : rd_q;
  assign wdata    = {s1_px_q, col_word[31:8]};

  // Shift the window left and insert the new column
  always_comb begin
    for (int r = 0; r < mf5_pkg::WinSize; r++) begin
      for (int c = 0; c < mf5_pkg::WinSize - 1; c++) begin
        win_d[r*mf5_pkg::WinSize + c] = win_q[r*mf5_pkg::WinSize + c + 1];
      end
    end
    for (int r = 0; r < mf5_pkg::WinSize - 1; r++) begin
      win_d[r*mf5_pkg::WinSize + mf5_pkg::WinSize - 1] = col_word[r*8 +: 8];
    end
    win_d[mf5_pkg::WinArea - 1] = s1_px_q;
  end

  always_ff @(posedge clk_i) begin
    if (proc) win_q <= win_d;
  end

  assign win_o        = win_d;
  assign meta_o.valid = s1_valid_q && s1_res_q;
  assign meta_o.col   = s1_col_q;
  assign meta_o.row   = s1_row_q;
  assign meta_o.done  = s1_done_q;

  // Counters wrap at the end of a frame
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && frame_end |=> col_q == 8'd0 && row_q == 12'd0)
    else $error("counters did not wrap at frame end");

  // A result only leaves for interior centers
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meta_o.valid |-> s1_col_q >= 8'd2 && s1_row_q >= 12'd2)
    else $error("result for a border pixel");

  // The column counter stays within the row in use
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i && !row_end |=> {1'b0, col_q} < w_use || $past(width_i) != width_i)
    else $error("column counter ran past the row");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned LineWidth = 256;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned HoldOffCycles = 400;

  typedef struct {
    logic [7:0]  median;
    logic [7:0]  col;
    logic [11:0] row;
    logic        done;
  } median_exp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  pixel_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  median_value_o;
  logic [7:0]  center_col_o;
  logic [11:0] center_row_o;
  logic        frame_done_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [11:0] cfg_data_i;

  // Shadow copy of the filter state
  logic [7:0]  line_mem [4][LineWidth];
  logic [7:0]  win_mem [mf5_pkg::WinSize][mf5_pkg::WinSize];
  int unsigned col_cnt;
  int unsigned row_cnt;
  logic [8:0]  width_reg;
  logic [11:0] height_reg;

  median_exp_t pending_medians[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int          hold_left;
  int unsigned mismatches;
  int unsigned medians_seen;
  int unsigned pixels_sent;
  int unsigned frames_sent;
  int unsigned quiet_cycles;

  median_filter_5x5 #(.LINE_WIDTH(LineWidth)) DUT (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned width_used();
    int unsigned w;
    w = width_reg;
    if (w < mf5_pkg::WinSize) w = mf5_pkg::WinSize;
    if (w > mf5_pkg::MaxCols) w = mf5_pkg::MaxCols;
    return w;
  endfunction

  function automatic int unsigned height_used();
    return (height_reg < mf5_pkg::WinSize) ? mf5_pkg::WinSize : height_reg;
  endfunction

  function automatic logic [7:0] window_median();
    logic [7:0] vals [mf5_pkg::WinArea];
    logic [7:0] key;
    int j;
    for (int r = 0; r < mf5_pkg::WinSize; r++)
      for (int c = 0; c < mf5_pkg::WinSize; c++)
        vals[r*mf5_pkg::WinSize+c] = win_mem[r][c];
    for (int i = 1; i < mf5_pkg::WinArea; i++) begin
      key = vals[i];
      j = i - 1;
      while (j >= 0 && vals[j] > key) begin
        vals[j+1] = vals[j];
        j--;
      end
      vals[j+1] = key;
    end
    return vals[mf5_pkg::MedianRank];
  endfunction

  // Advance the shadow filter by one pixel and queue any median it yields
  task automatic predict_pixel(input logic [7:0] px);
    logic [7:0]  column [mf5_pkg::WinSize];
    int unsigned slot;
    logic        row_end;
    logic        frame_end;
    median_exp_t e;
    slot = (col_cnt < LineWidth) ? col_cnt : LineWidth - 1;
    for (int r = 0; r < 4; r++) column[r] = line_mem[r][slot];
    column[4] = px;
    for (int r = 0; r < mf5_pkg::WinSize; r++) begin
      for (int c = 0; c < mf5_pkg::WinSize - 1; c++) win_mem[r][c] = win_mem[r][c+1];
      win_mem[r][mf5_pkg::WinSize-1] = column[r];
    end
    for (int r = 0; r < 3; r++) line_mem[r][slot] = column[r+1];
    line_mem[3][slot] = px;
    row_end = (col_cnt + 1 >= width_used());
    frame_end = row_end && (row_cnt + 1 >= height_used());
    if (col_cnt >= 4 && row_cnt >= 4) begin
      e.median = window_median();
      e.col = 8'(col_cnt - 2);
      e.row = 12'(row_cnt - 2);
      e.done = frame_end;
      pending_medians.push_back(e);
    end
    if (frame_end) begin
      col_cnt = 0;
      row_cnt = 0;
    end else if (row_end) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1) & 12'hFFF;
    end else begin
      col_cnt = (col_cnt + 1) & 8'hFF;
    end
  endtask

  // Offer one pixel, with a random gap first, and hold it until taken
  task automatic send_pixel(input logic [7:0] px);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    predict_pixel(px);
    pixels_sent++;
  endtask

  // Wait for every queued median, then let the pipeline empty
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer one register write and hold it until taken
  task automatic write_reg(input mf5_pkg::reg_idx_e idx, input logic [11:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == mf5_pkg::RegWidth) width_reg = data[8:0];
    else height_reg = data;
  endtask

  task automatic set_size(input logic [11:0] w, input logic [11:0] h);
    drain();
    write_reg(mf5_pkg::RegWidth, w);
    write_reg(mf5_pkg::RegHeight, h);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] random_pixel();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 8'hFF : 8'h00;
      1: return 8'($urandom_range(3)) + 8'd126;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame();
    int unsigned n;
    n = width_used() * height_used();
    for (int unsigned i = 0; i < n; i++) send_pixel(random_pixel());
    frames_sent++;
  endtask

  // Two smallest frames with hand-picked pixels: extremes and a central peak, then a half-bright frame
  task automatic test_directed();
    set_size(12'd5, 12'd5);
    for (int i = 0; i < 25; i++) begin
      if (i == 12) send_pixel(8'hFF);
      else if (i % 2 == 0) send_pixel(8'h00);
      else send_pixel(8'(i * 9));
    end
    frames_sent++;
    set_size(12'd5, 12'd5);
    for (int i = 0; i < 25; i++) send_pixel((i < 13) ? 8'hFF : 8'h00);
    frames_sent++;
  endtask

  // Register extremes, including out-of-range widths and heights
  task automatic test_size_extremes();
    set_size(12'd0, 12'd0);
    send_frame();
    set_size(12'h1FF, 12'd5);
    send_frame();
    set_size(12'hE00 | 12'd6, 12'd4);
    send_frame();
    set_size(12'd3, 12'd20);
    send_frame();
  endtask

  // Long receiver hold-off while pixels keep coming, so the input stalls
  task automatic test_backpressure();
    set_size(12'd8, 12'd8);
    hold_left = HoldOffCycles;
    send_frame();
    send_frame();
  endtask

  // Random small frames across three idling phases
  task automatic test_random_frames();
    int unsigned start;
    start = pixels_sent;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 46 : 0;
      recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 36 : 0;
      while (pixels_sent - start < (phase + 1) * 110) begin
        set_size(12'($urandom_range(12, 5)), 12'($urandom_range(9, 5)));
        send_frame();
      end
    end
  endtask

  // Receiver: random ready, hold-off, and median check
  always @(posedge clk_i) begin
    median_exp_t e;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      medians_seen++;
      if (pending_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected median item at %0t", $realtime);
      end else begin
        e = pending_medians.pop_front();
        if (median_value_o !== e.median || center_col_o !== e.col ||
            center_row_o !== e.row || frame_done_o !== e.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp med=%0d col=%0d row=%0d done=%0d, got %0d %0d %0d %0d",
                     $realtime, e.median, e.col, e.row, e.done,
                     median_value_o, center_col_o, center_row_o, frame_done_o);
        end
      end
    end
  end

  // Watchdog: cycles with no item accepted on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("median_filter_5x5 verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pixel_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = mf5_pkg::RegWidth;
    cfg_data_i = '0;
    send_idle_pct = 36;
    recv_idle_pct = 46;
    hold_left = 0;
    mismatches = 0;
    medians_seen = 0;
    pixels_sent = 0;
    frames_sent = 0;
    quiet_cycles = 0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = 9'd256;
    height_reg = 12'd256;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_size_extremes();
    test_backpressure();
    test_random_frames();
    drain();

    if (pending_medians.size() != 0) mismatches++;
    $display("covered %0d pixels in %0d frames, %0d medians checked,", pixels_sent,
             frames_sent, medians_seen);
    $display("sizes from the clamped minimum to full width, with long output stalls");
    if (mismatches == 0) begin
      $display("median_filter_5x5 verification clean");
    end else begin
      $display("median_filter_5x5 verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mf5_pkg.sv
hdl/mf5_cell.sv
hdl/mf5_front.sv
hdl/median_filter_5x5.sv
verif/testbench.sv
